FILE: rtl/core/sosp_pkg.sv
// Shared constants, codes and types of the set-of-stacks block.
package sosp_pkg;

	// Fixed field widths of the channels
	localparam int CMD_W   = 2;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = 6;
	localparam int LIM_W   = 7;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	// Defaults for the top-level parameters
	localparam int STORE_DEPTH_DEF = 64;
	localparam int VALUE_WIDTH_DEF = 32;

	// Reset value of the sub-stack limit register
	localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd1;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP_AT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

	// Per-cycle control broadcast to every cell
	typedef struct packed {
		logic push;    // every cell takes its upper neighbor, cell 0 the new entry
		logic remove;  // cells at or below the removal point take their lower neighbor
	} cell_ctl_t;

endpackage

FILE: rtl/core/sosp_if.sv
// Handshake channels of the set-of-stacks block: command, result and limit write.
interface sosp_cmd_if;
	logic                        valid;
	logic                        ready;
	logic [sosp_pkg::CMD_W-1:0]  command;
	logic [sosp_pkg::DATA_W-1:0] push_value;
	logic [sosp_pkg::IDX_W-1:0]  sub_stack_index;

	modport source (output valid, command, push_value, sub_stack_index, input ready);
	modport sink   (input valid, command, push_value, sub_stack_index, output ready);
endinterface

interface sosp_res_if;
	logic                         valid;
	logic                         ready;
	logic [sosp_pkg::DATA_W-1:0]  top_value;
	logic                         is_empty;
	logic [sosp_pkg::COUNT_W-1:0] entry_count;
	logic [sosp_pkg::STAT_W-1:0]  status;

	modport source (output valid, top_value, is_empty, entry_count, status, input ready);
	modport sink   (input valid, top_value, is_empty, entry_count, status, output ready);
endinterface

interface sosp_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [sosp_pkg::LIM_W-1:0] sub_stack_limit;

	modport source (output valid, sub_stack_limit, input ready);
	modport sink   (input valid, sub_stack_limit, output ready);
endinterface

FILE: rtl/core/sosp_cell.sv
// One storage cell of the stack chain, ordered from the top entry downward.
module sosp_cell #(
	parameter int INDEX       = 0,
	parameter int VALUE_WIDTH = sosp_pkg::VALUE_WIDTH_DEF,
	parameter int COUNT_WIDTH = 7
) (
	input  logic                    clk,
	input  sosp_pkg::cell_ctl_t     ctl,
	input  logic [COUNT_WIDTH-1:0]  shift_from,
	input  logic [VALUE_WIDTH-1:0]  upper_in,
	input  logic [VALUE_WIDTH-1:0]  lower_in,
	output logic [VALUE_WIDTH-1:0]  entry_q
);

	localparam logic [COUNT_WIDTH-1:0] POS = COUNT_WIDTH'(INDEX);

	// Push moves everything one place down; a removal closes the gap from below.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entry_q <= upper_in;
		end else if (ctl.remove && (POS >= shift_from)) begin
			entry_q <= lower_in;
		end
	end

endmodule

FILE: rtl/core/sosp_ctrl.sv
// Command decode, entry count, limit register and result register of the stack.
module sosp_ctrl #(
	parameter int STORE_DEPTH = sosp_pkg::STORE_DEPTH_DEF,
	parameter int VALUE_WIDTH = sosp_pkg::VALUE_WIDTH_DEF,
	localparam int CW = $clog2(STORE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	sosp_cmd_if.sink               cmd,
	sosp_res_if.source             res,
	sosp_cfg_if.sink               cfg,
	output sosp_pkg::cell_ctl_t    ctl,
	output logic [CW-1:0]          shift_from,
	output logic [VALUE_WIDTH-1:0] push_entry,
	input  logic [VALUE_WIDTH-1:0] top_entry,
	input  logic [VALUE_WIDTH-1:0] second_entry
);

	localparam int PROD_W = sosp_pkg::IDX_W + sosp_pkg::LIM_W + 1;
	localparam int PW     = (PROD_W > CW) ? PROD_W : CW;
	localparam logic [CW-1:0] FULL_COUNT = CW'(STORE_DEPTH);

	logic [sosp_pkg::LIM_W-1:0]   limit_q;
	logic [CW-1:0]                count_q;
	logic                         res_valid_q;
	logic [sosp_pkg::DATA_W-1:0]  res_top_q;
	logic                         res_empty_q;
	logic [sosp_pkg::COUNT_W-1:0] res_count_q;
	logic [sosp_pkg::STAT_W-1:0]  res_status_q;

	logic                         accept;
	logic [sosp_pkg::LIM_W-1:0]   limit_eff;
	logic [PW-1:0]                sub_base;
	logic [PW-1:0]                sub_end;
	logic [PW-1:0]                count_x;
	logic                         in_range;
	logic [CW-1:0]                count_next;
	logic [sosp_pkg::STAT_W-1:0]  status_next;
	logic [VALUE_WIDTH-1:0]       top_next;

	assign cfg.ready = 1'b1;
	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign push_entry = VALUE_WIDTH'(signed'(cmd.push_value));

	// Sub-stack i spans [i*limit, (i+1)*limit); a limit of zero acts as one.
	assign limit_eff = (limit_q == '0) ? sosp_pkg::LIM_W'(1) : limit_q;
	assign sub_base  = PW'(cmd.sub_stack_index) * PW'(limit_eff);
	assign sub_end   = sub_base + PW'(limit_eff);
	assign count_x   = PW'(count_q);
	assign in_range  = sub_base < count_x;

	always_comb begin
		ctl         = '0;
		shift_from  = '0;
		count_next  = count_q;
		status_next = sosp_pkg::ST_OK;
		case (cmd.command)
			sosp_pkg::CMD_PUSH: begin
				if (count_q == FULL_COUNT) begin
					status_next = sosp_pkg::ST_FULL;
				end else begin
					ctl.push   = accept;
					count_next = count_q + CW'(1);
				end
			end
			sosp_pkg::CMD_POP: begin
				if (count_q == '0) begin
					status_next = sosp_pkg::ST_EMPTY;
				end else begin
					ctl.remove = accept;
					count_next = count_q - CW'(1);
				end
			end
			sosp_pkg::CMD_POP_AT: begin
				if (!in_range) begin
					status_next = sosp_pkg::ST_RANGE;
				end else begin
					ctl.remove = accept;
					count_next = count_q - CW'(1);
					// Depth from the top of the removed entry
					if (sub_end < count_x) begin
						shift_from = CW'(count_x - sub_end);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (ctl.push) begin
			top_next = push_entry;
		end else if (ctl.remove && (shift_from == '0)) begin
			top_next = second_entry;
		end else begin
			top_next = top_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= sosp_pkg::LIMIT_RESET;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				limit_q <= cfg.sub_stack_limit;
			end
			if (accept) begin
				count_q     <= count_next;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_top_q    <= (count_next == '0) ? '1 : sosp_pkg::DATA_W'(signed'(top_next));
			res_empty_q  <= (count_next == '0);
			res_count_q  <= sosp_pkg::COUNT_W'(count_next);
			res_status_q <= status_next;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.top_value   = res_top_q;
	assign res.is_empty    = res_empty_q;
	assign res.entry_count = res_count_q;
	assign res.status      = res_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("entry count beyond store depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not add one entry");

	a_peek_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.command == sosp_pkg::CMD_PEEK) |=> $stable(count_q))
		else $error("peek changed the entry count");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_status_q == sosp_pkg::ST_FULL)
			|-> res_count_q == sosp_pkg::COUNT_W'(FULL_COUNT))
		else $error("full status with room left");

	a_no_move_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(status_next != sosp_pkg::ST_OK) |-> !ctl.push && !ctl.remove)
		else $error("cells moved on a refused command");

endmodule

FILE: rtl/core/set_of_stacks_with_pop_at.sv
// Top level of the set-of-stacks block: control unit and the chain of storage cells.
// Set of stacks with pop-at, rollover form. The store is one flat stack cut into
// sub-stacks of sub_stack_limit entries (a limit of zero acts as one); commands are
// push, pop, pop-at a sub-stack index, and peek, and each accepted command item
// yields exactly one result item carrying the top entry (all ones when empty), an
// empty flag, the entry count and a status (ok, push refused full, pop on empty,
// index out of range). For each command, an item is accepted,
// all cells update at that edge, and the result sits in an output register, so a
// new command is taken in each cycle while the result side keeps up. The entries
// live in a row of STORE_DEPTH cells ordered from the top downward, so the top is
// always the first cell; push shifts the whole row down, and pop or pop-at closes
// the gap by pulling every cell at or below the removal point up from its lower
// neighbor in the same cycle. The pop-at position comes from one small
// index-by-limit product and a subtract against the count in the control unit.
// Write the limit only while no command is in flight. No clearing pass is needed
// after reset; cells beyond the count are never shown.
module set_of_stacks_with_pop_at #(
	parameter int STORE_DEPTH = sosp_pkg::STORE_DEPTH_DEF,
	parameter int VALUE_WIDTH = sosp_pkg::VALUE_WIDTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	sosp_cmd_if.sink   cmd,
	sosp_res_if.source res,
	sosp_cfg_if.sink   cfg
);

	localparam int CW = $clog2(STORE_DEPTH + 1);

	sosp_pkg::cell_ctl_t    ctl;
	logic [CW-1:0]          shift_from;
	logic [VALUE_WIDTH-1:0] push_entry;
	logic [VALUE_WIDTH-1:0] cell_q [STORE_DEPTH];

	// Decode commands, track the count and hold the result item
	sosp_ctrl #(
		.STORE_DEPTH (STORE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.res          (res),
		.cfg          (cfg),
		.ctl          (ctl),
		.shift_from   (shift_from),
		.push_entry   (push_entry),
		.top_entry    (cell_q[0]),
		.second_entry (cell_q[1])
	);

	// Row of cells; cell 0 is the top of the stack
	for (genvar k = 0; k < STORE_DEPTH; k++) begin : g_cell
		logic [VALUE_WIDTH-1:0] upper;
		logic [VALUE_WIDTH-1:0] lower;

		// The top cell takes the pushed entry; the others take their upper neighbor.
		if (k == 0) begin : g_top
			assign upper = push_entry;
		end else begin : g_mid
			assign upper = cell_q[k-1];
		end

		// The bottom cell has nothing below it: hold its own entry.
		if (k == STORE_DEPTH - 1) begin : g_bottom
			assign lower = cell_q[k];
		end else begin : g_above
			assign lower = cell_q[k+1];
		end

		sosp_cell #(
			.INDEX       (k),
			.VALUE_WIDTH (VALUE_WIDTH),
			.COUNT_WIDTH (CW)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.shift_from (shift_from),
			.upper_in   (upper),
			.lower_in   (lower),
			.entry_q    (cell_q[k])
		);
	end

endmodule

FILE: test/set_of_stacks_with_pop_at_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the set-of-stacks block with pop at a sub-stack index.

module set_of_stacks_with_pop_at_test;
	import sosp_pkg::*;

	localparam int DEPTH        = STORE_DEPTH_DEF;
	localparam int RESET_CYCLES = 12;
	localparam int HOLD_CYCLES  = 300;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int NUM_PHASES   = 12;
	localparam int PHASE_ITEMS  = 100;
	localparam int TAIL_CYCLES  = 8;

	// What one result item carries, in the order of the result channel
	typedef struct packed {
		logic [DATA_W-1:0]  top;
		logic               empty;
		logic [COUNT_W-1:0] count;
		logic [STAT_W-1:0]  status;
	} stack_view_t;

	typedef enum logic {ROW_CMD, ROW_LIMIT} row_kind_e;

	// One row of the directed table: either a command item or a limit write.
	// Rows with typed set carry a hand-written expectation.
	typedef struct {
		row_kind_e          kind;
		logic [CMD_W-1:0]   op;
		logic [DATA_W-1:0]  value;
		logic [IDX_W-1:0]   index;
		logic [LIM_W-1:0]   limit;
		bit                 typed;
		stack_view_t        want;
	} plan_row_t;

	logic clk;
	logic arst_n;

	sosp_cmd_if cmd_ch();
	sosp_res_if res_ch();
	sosp_cfg_if cfg_ch();

	set_of_stacks_with_pop_at u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the flat store, its fill level and the limit register
	logic [DATA_W-1:0] shadow_entries [DEPTH];
	int                shadow_used  = 0;
	logic [LIM_W-1:0]  shadow_limit = LIMIT_RESET;

	// Views still owed by the block, oldest first
	stack_view_t pending_views[$];
	plan_row_t   plan_table[$];

	int error_count  = 0;
	int result_count = 0;
	int cycle_count  = 0;
	bit hold_request = 1'b0;
	bit quiet        = 1'b0;

	// Free-running clock, 4 ns period
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d views pending", cycle_count,
				pending_views.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Apply one command to the shadow store and return what the block must show after it.
	// Pop at i removes flat position min((i+1)*limit, used)-1 and closes the gap from above.
	function automatic stack_view_t apply_stack_op(input logic [CMD_W-1:0] op,
			input logic [DATA_W-1:0] value, input logic [IDX_W-1:0] index);
		stack_view_t view;
		int          lim;
		int          subs;
		int          cut;
		view.status = ST_OK;
		// a zero limit behaves like one
		lim = (shadow_limit == '0) ? 1 : int'(shadow_limit);
		case (op)
			CMD_PUSH: begin
				if (shadow_used >= DEPTH) begin
					view.status = ST_FULL;
				end else begin
					shadow_entries[shadow_used] = value;
					shadow_used++;
				end
			end
			CMD_POP: begin
				if (shadow_used == 0)
					view.status = ST_EMPTY;
				else
					shadow_used--;
			end
			CMD_POP_AT: begin
				subs = (shadow_used + lim - 1) / lim;
				if (int'(index) >= subs) begin
					view.status = ST_RANGE;
				end else begin
					cut = (int'(index) + 1) * lim;
					if (cut > shadow_used)
						cut = shadow_used;
					for (int k = cut - 1; k < shadow_used - 1; k++)
						shadow_entries[k] = shadow_entries[k + 1];
					shadow_used--;
				end
			end
			default: begin
			end
		endcase
		view.empty = (shadow_used == 0);
		view.top   = view.empty ? {DATA_W{1'b1}} : shadow_entries[shadow_used - 1];
		view.count = COUNT_W'(shadow_used);
		return view;
	endfunction

	function automatic plan_row_t op_row(input logic [CMD_W-1:0] op,
			input logic [DATA_W-1:0] value, input logic [IDX_W-1:0] index,
			input bit typed, input stack_view_t want);
		plan_row_t row;
		row.kind  = ROW_CMD;
		row.op    = op;
		row.value = value;
		row.index = index;
		row.limit = '0;
		row.typed = typed;
		row.want  = want;
		return row;
	endfunction

	function automatic plan_row_t limit_row(input logic [LIM_W-1:0] limit);
		plan_row_t row;
		row       = op_row(CMD_PEEK, '0, '0, 1'b0, '0);
		row.kind  = ROW_LIMIT;
		row.limit = limit;
		return row;
	endfunction

	// Append one row at the end of the directed table
	function automatic void add_row(input plan_row_t row);
		plan_table.insert(plan_table.size(), row);
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("ERROR result %0d %s: got %h, expected %h", result_count, what, got, want);
		error_count++;
	endtask

	// Compare one accepted result item with the oldest pending view
	task automatic check_result();
		stack_view_t got;
		stack_view_t want;
		got = {res_ch.top_value, res_ch.is_empty, res_ch.entry_count, res_ch.status};
		result_count++;
		if (pending_views.size() == 0) begin
			report_mismatch("arrived with nothing pending", got.top, '0);
			return;
		end
		want = pending_views.pop_front();
		if (got.top !== want.top)
			report_mismatch("top_value", got.top, want.top);
		if (got.empty !== want.empty)
			report_mismatch("is_empty", DATA_W'(got.empty), DATA_W'(want.empty));
		if (got.count !== want.count)
			report_mismatch("entry_count", DATA_W'(got.count), DATA_W'(want.count));
		if (got.status !== want.status)
			report_mismatch("status", DATA_W'(got.status), DATA_W'(want.status));
	endtask

	// Offer one command item and hold it until the block takes it; valid stays high
	// afterwards so back-to-back items never drop it within a step.
	task automatic send_item(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] value,
			input logic [IDX_W-1:0] index, input bit typed, input stack_view_t want);
		stack_view_t view;
		cmd_ch.valid           <= 1'b1;
		cmd_ch.command         <= op;
		cmd_ch.push_value      <= value;
		cmd_ch.sub_stack_index <= index;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		view = apply_stack_op(op, value, index);
		if (typed)
			view = want;
		pending_views.insert(pending_views.size(), view);
	endtask

	task automatic idle_sender(input int cycles);
		cmd_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Drop valid, wait until every pending view has been seen (every item yields a
	// result), then wait on before returning.
	task automatic settle_store();
		cmd_ch.valid <= 1'b0;
		while (pending_views.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIM_W-1:0] limit);
		cfg_ch.valid           <= 1'b1;
		cfg_ch.sub_stack_limit <= limit;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		shadow_limit = limit;
	endtask

	// Result side: mostly ready, with random stall bursts, and one long hold-off on request
	// so the output backs up and the command side has to stall.
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15) - 1) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Monitor: sample the result channel at every edge
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
				check_result();
		end
	end

	// Stimulus: directed table first, then random phases under changing limits
	initial begin
		int               p;
		int               n;
		int               pick;
		int               push_pct;
		int               gap_pct;
		int               lim;
		int               subs;
		logic [CMD_W-1:0] op;
		logic [DATA_W-1:0] value;
		logic [IDX_W-1:0] index;
		logic [LIM_W-1:0] next_limit;

		arst_n                 <= 1'b0;
		cmd_ch.valid           <= 1'b0;
		cmd_ch.command         <= CMD_PEEK;
		cmd_ch.push_value      <= '0;
		cmd_ch.sub_stack_index <= '0;
		cfg_ch.valid           <= 1'b0;
		cfg_ch.sub_stack_limit <= LIMIT_RESET;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty store after reset: peek, pop and pop at must all leave it alone
		add_row(op_row(CMD_PEEK, '0, '0, 1'b1,
			{32'hFFFF_FFFF, 1'b1, 7'd0, ST_OK}));
		add_row(op_row(CMD_POP, '1, '1, 1'b1,
			{32'hFFFF_FFFF, 1'b1, 7'd0, ST_EMPTY}));
		add_row(op_row(CMD_POP_AT, '0, 6'd0, 1'b1,
			{32'hFFFF_FFFF, 1'b1, 7'd0, ST_RANGE}));
		add_row(op_row(CMD_POP_AT, '0, 6'd63, 1'b1,
			{32'hFFFF_FFFF, 1'b1, 7'd0, ST_RANGE}));
		// Extreme values, limit one, so each entry is its own sub-stack
		add_row(op_row(CMD_PUSH, 32'h7FFF_FFFF, '0, 1'b1,
			{32'h7FFF_FFFF, 1'b0, 7'd1, ST_OK}));
		add_row(op_row(CMD_PUSH, 32'h8000_0000, '1, 1'b1,
			{32'h8000_0000, 1'b0, 7'd2, ST_OK}));
		add_row(op_row(CMD_PUSH, 32'hFFFF_FFFF, '0, 1'b1,
			{32'hFFFF_FFFF, 1'b0, 7'd3, ST_OK}));
		add_row(op_row(CMD_PUSH, 32'h0000_0000, '0, 1'b1,
			{32'h0000_0000, 1'b0, 7'd4, ST_OK}));
		add_row(op_row(CMD_POP_AT, '0, 6'd63, 1'b1,
			{32'h0000_0000, 1'b0, 7'd4, ST_RANGE}));
		// Pop at from the middle, then from the top sub-stack
		add_row(op_row(CMD_POP_AT, '0, 6'd1, 1'b0, '0));
		add_row(op_row(CMD_PEEK, '0, '0, 1'b0, '0));
		add_row(op_row(CMD_POP_AT, '0, 6'd2, 1'b0, '0));
		add_row(op_row(CMD_POP, '0, '0, 1'b0, '0));
		// Zero limit, written while entries are held: behaves like one
		add_row(limit_row(7'd0));
		add_row(op_row(CMD_PUSH, 32'h5555_5555, 6'h2A, 1'b0, '0));
		add_row(op_row(CMD_PUSH, 32'hAAAA_AAAA, 6'h15, 1'b0, '0));
		add_row(op_row(CMD_POP_AT, '0, 6'd1, 1'b0, '0));
		// Limit above the count: the whole store is one sub-stack
		add_row(limit_row(7'd127));
		add_row(op_row(CMD_PUSH, 32'h1234_5678, '0, 1'b0, '0));
		add_row(op_row(CMD_POP_AT, '0, 6'd0, 1'b0, '0));
		add_row(op_row(CMD_POP_AT, '0, 6'd1, 1'b1,
			{32'hAAAA_AAAA, 1'b0, 7'd2, ST_RANGE}));
		add_row(limit_row(7'd64));
		add_row(op_row(CMD_POP, '0, '0, 1'b0, '0));
		add_row(op_row(CMD_POP, '0, '0, 1'b1,
			{32'hFFFF_FFFF, 1'b1, 7'd0, ST_OK}));
		add_row(op_row(CMD_PEEK, '1, '1, 1'b0, '0));

		foreach (plan_table[r]) begin
			if (plan_table[r].kind == ROW_LIMIT) begin
				settle_store();
				write_limit(plan_table[r].limit);
			end else begin
				if ($urandom_range(0, 3) == 0)
					idle_sender($urandom_range(1, 15));
				send_item(plan_table[r].op, plan_table[r].value, plan_table[r].index,
					plan_table[r].typed, plan_table[r].want);
			end
		end

		// Random phases: even phases lean on push so the store fills up and refuses,
		// odd ones lean on pop and pop at so it drains to empty. Each phase starts
		// from an idle block with a fresh limit; the store is usually not empty then.
		for (p = 0; p < NUM_PHASES; p++) begin
			settle_store();
			case (p)
				0: next_limit = 7'd64;
				1: next_limit = 7'd1;
				2: next_limit = 7'd0;
				3: next_limit = 7'd127;
				4: next_limit = 7'd2;
				5: next_limit = 7'd3;
				default: begin
					if (p % 3 == 0)
						next_limit = LIM_W'($urandom_range(0, 127));
					else
						next_limit = LIM_W'($urandom_range(1, 64));
				end
			endcase
			write_limit(next_limit);
			// last phase runs at full rate on both sides
			quiet    = (p == NUM_PHASES - 1);
			push_pct = (p % 2 == 0) ? 85 : 25;
			gap_pct  = (quiet || p % 3 == 1) ? 0 : 15;

			for (n = 0; n < PHASE_ITEMS; n++) begin
				// long result hold-off while commands keep coming
				if (p == 3 && n == 20)
					hold_request = 1'b1;
				// sender pause until the block has answered everything
				if (p == 5 && n == 50)
					settle_store();
				if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
					idle_sender($urandom_range(1, 15));

				value = $urandom();
				index = IDX_W'($urandom_range(0, 63));
				pick  = $urandom_range(0, 99);
				if (pick < push_pct) begin
					op = CMD_PUSH;
					if ($urandom_range(0, 7) == 0) begin
						case ($urandom_range(0, 3))
							0: value = 32'h0000_0000;
							1: value = 32'h7FFF_FFFF;
							2: value = 32'h8000_0000;
							default: value = 32'hFFFF_FFFF;
						endcase
					end
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 35)
						op = CMD_POP;
					else if (pick < 80)
						op = CMD_POP_AT;
					else
						op = CMD_PEEK;
				end
				// aim pop at mostly at existing sub-stacks, sometimes anywhere
				if (op == CMD_POP_AT) begin
					lim  = (shadow_limit == '0) ? 1 : int'(shadow_limit);
					subs = (shadow_used + lim - 1) / lim;
					if (subs > 0 && $urandom_range(0, 3) != 0)
						index = IDX_W'($urandom_range(0, subs - 1));
				end
				send_item(op, value, index, 1'b0, '0);
			end
		end

		settle_store();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
